[hw/rtl/ddmc_pkg.sv]
`timescale 1ns / 1ps

package ddmc_pkg;

	localparam int InW      = 136;
	localparam int OutW     = 24;
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] CfgSafeDistance = 8'd0;
	localparam logic [CfgIdxW-1:0] CfgArrivalTol   = 8'd1;
	localparam logic [CfgIdxW-1:0] CfgBaseSpeed    = 8'd2;
	localparam logic [CfgIdxW-1:0] CfgSteerLimit   = 8'd3;

	localparam logic [31:0] SafeDistanceRst = 32'd1000;
	localparam logic [23:0] ArrivalTolRst   = 24'd500;
	localparam logic [7:0]  BaseSpeedRst    = 8'd128;
	localparam logic [7:0]  SteerLimitRst   = 8'd100;

	localparam logic [7:0]  AvoidFastPwm = 8'd100;
	localparam logic [7:0]  AvoidSlowPwm = 8'd50;
	localparam logic [7:0]  ReversePwm   = 8'd80;
	localparam logic [7:0]  PwmMax       = 8'd255;

	localparam logic [12:0] BearingFull = 13'd5760;
	localparam logic [12:0] BearingMax  = 13'd5759;
	localparam logic [12:0] BearingHalf = 13'd2880;

	// input word, first field in the high bits
	typedef struct packed {
		logic [12:0] waypoint_bearing;
		logic [23:0] waypoint_distance_cm;
		logic        gps_fix;
		logic        estop_req;
		logic [31:0] front_right_range;
		logic [31:0] front_left_range;
		logic        mode_button;
		logic [15:0] joy_y;
		logic [15:0] joy_x;
	} in_word_t;

	// result word, first field in the high bits
	typedef struct packed {
		logic       forced_stop;
		logic       avoidance_active;
		logic       drive_mode;
		logic       right_dir;
		logic       left_dir;
		logic [7:0] right_duty;
		logic [7:0] left_duty;
	} out_word_t;

	localparam int OutFieldW = $bits(out_word_t);

	typedef struct packed {
		logic [7:0] pwm;
		logic       fwd;
	} side_t;

endpackage

[hw/rtl/differential_drive_mode_controller_core.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Signals                                  | Word
// s_axis   | in  | s_axis_tvalid/tready/tdata[135:0]        | one control tick
// m_axis   | out | m_axis_tvalid/tready/tdata[23:0]         | one motor command
// cfg      | in  | cfg_we, cfg_index[7:0], cfg_data[31:0]   | register write
//
// One word per clock sustained while m_axis takes results; a word passes the input
// register, then the result register, with one logic level between.
// Held command and mode update as the result register loads.
// Reset: registers to defaults, mode manual, held command zero, pipeline empty.
// A stall on m_axis holds the result; s_axis keeps accepting until the input
// register is also full.

module differential_drive_mode_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// joy_x, joy_y, mode_button, front_left_range, front_right_range,
	// estop_req, gps_fix, waypoint_distance_cm, waypoint_bearing
	input  logic [ddmc_pkg::InW-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// left_duty, right_duty, left_dir, right_dir, drive_mode,
	// avoidance_active, forced_stop, zero pad
	output logic [ddmc_pkg::OutW-1:0]     m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [ddmc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ddmc_pkg::CfgDataW-1:0] cfg_data
);
	import ddmc_pkg::*;

	function automatic logic signed [8:0] div128(logic [15:0] v);
		logic signed [16:0] t;
		t = $signed({v[15], v}) + (v[15] ? 17'sd127 : 17'sd0);
		return t[15:7];
	endfunction

	function automatic side_t to_side(logic signed [10:0] speed);
		side_t s;
		logic signed [10:0] mag;
		mag = speed[10] ? -speed : speed;
		s.fwd = !speed[10];
		s.pwm = (mag > 11'sd255) ? PwmMax : mag[7:0];
		return s;
	endfunction

	logic [31:0] safe_distance_q;
	logic [23:0] arrival_tol_q;
	logic [7:0]  base_speed_q;
	logic [7:0]  steer_limit_q;

	logic        mode_q;
	logic [7:0]  held_left_pwm_q, held_right_pwm_q;
	logic        held_left_fwd_q, held_right_fwd_q;

	logic        valid_s1;
	in_word_t    word_s1;
	logic        valid_s2;
	out_word_t   res_s2;

	logic        adv_s2, load_s2;
	out_word_t   res_nx;

	logic                mode_nx;
	logic signed [8:0]   fwd_m, turn_m;
	logic signed [10:0]  left_mix, right_mix;
	side_t               man_l, man_r, str_l, str_r;
	logic                lb, rb;
	logic [12:0]         b1;
	logic signed [13:0]  err;
	logic signed [13:0]  err_t;
	logic signed [9:0]   steer, steer_c, lim;
	logic signed [10:0]  left_str, right_str;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign load_s2       = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OutW-OutFieldW){1'b0}}, res_s2};

	always_comb begin
		mode_nx   = mode_q ^ word_s1.mode_button;

		fwd_m     = div128(word_s1.joy_y);
		turn_m    = div128(word_s1.joy_x);
		left_mix  = {{2{fwd_m[8]}}, fwd_m} - {{2{turn_m[8]}}, turn_m};
		right_mix = {{2{fwd_m[8]}}, fwd_m} + {{2{turn_m[8]}}, turn_m};
		man_l     = to_side(left_mix);
		man_r     = to_side(right_mix);

		lb = word_s1.front_left_range < safe_distance_q;
		rb = word_s1.front_right_range < safe_distance_q;

		b1 = (word_s1.waypoint_bearing > BearingMax) ?
			word_s1.waypoint_bearing - BearingFull : word_s1.waypoint_bearing;
		err = (b1 > BearingHalf) ? $signed({1'b0, b1}) - $signed({1'b0, BearingFull})
			: $signed({1'b0, b1});
		err_t   = err + (err[13] ? 14'sd7 : 14'sd0);
		steer   = err_t[12:3];
		lim     = $signed({2'b00, steer_limit_q});
		steer_c = steer;
		if (steer > lim)
			steer_c = lim;
		if (steer < -lim)
			steer_c = -lim;
		left_str  = $signed({3'b000, base_speed_q}) - {steer_c[9], steer_c};
		right_str = $signed({3'b000, base_speed_q}) + {steer_c[9], steer_c};
		str_l     = to_side(left_str);
		str_r     = to_side(right_str);

		res_nx.left_duty        = held_left_pwm_q;
		res_nx.right_duty       = held_right_pwm_q;
		res_nx.left_dir         = held_left_fwd_q;
		res_nx.right_dir        = held_right_fwd_q;
		res_nx.drive_mode       = mode_nx;
		res_nx.avoidance_active = 1'b0;
		res_nx.forced_stop      = 1'b0;

		if (word_s1.estop_req) begin
			res_nx.left_duty   = '0;
			res_nx.right_duty  = '0;
			res_nx.left_dir    = 1'b1;
			res_nx.right_dir   = 1'b1;
			res_nx.forced_stop = 1'b1;
		end else if (word_s1.mode_button) begin
			// command held
		end else if (!mode_nx) begin
			res_nx.left_duty  = man_l.pwm;
			res_nx.left_dir   = man_l.fwd;
			res_nx.right_duty = man_r.pwm;
			res_nx.right_dir  = man_r.fwd;
		end else if (!word_s1.gps_fix) begin
			res_nx.left_duty   = '0;
			res_nx.right_duty  = '0;
			res_nx.left_dir    = 1'b1;
			res_nx.right_dir   = 1'b1;
			res_nx.forced_stop = 1'b1;
		end else if (lb || rb) begin
			res_nx.avoidance_active = 1'b1;
			if (lb && !rb) begin
				res_nx.left_duty  = AvoidFastPwm;
				res_nx.right_duty = AvoidSlowPwm;
				res_nx.left_dir   = 1'b1;
				res_nx.right_dir  = 1'b1;
			end else if (rb && !lb) begin
				res_nx.left_duty  = AvoidSlowPwm;
				res_nx.right_duty = AvoidFastPwm;
				res_nx.left_dir   = 1'b1;
				res_nx.right_dir  = 1'b1;
			end else begin
				res_nx.left_duty  = ReversePwm;
				res_nx.right_duty = ReversePwm;
				res_nx.left_dir   = 1'b0;
				res_nx.right_dir  = 1'b0;
			end
		end else if (word_s1.waypoint_distance_cm < arrival_tol_q) begin
			res_nx.left_duty  = '0;
			res_nx.right_duty = '0;
		end else begin
			res_nx.left_duty  = str_l.pwm;
			res_nx.left_dir   = str_l.fwd;
			res_nx.right_duty = str_r.pwm;
			res_nx.right_dir  = str_r.fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_distance_q <= SafeDistanceRst;
			arrival_tol_q   <= ArrivalTolRst;
			base_speed_q    <= BaseSpeedRst;
			steer_limit_q   <= SteerLimitRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgSafeDistance: safe_distance_q <= cfg_data;
				CfgArrivalTol:   arrival_tol_q   <= cfg_data[23:0];
				CfgBaseSpeed:    base_speed_q    <= cfg_data[7:0];
				CfgSteerLimit:   steer_limit_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			mode_q           <= 1'b0;
			held_left_pwm_q  <= '0;
			held_right_pwm_q <= '0;
			held_left_fwd_q  <= 1'b0;
			held_right_fwd_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (load_s2) begin
				mode_q           <= res_nx.drive_mode;
				held_left_pwm_q  <= res_nx.left_duty;
				held_right_pwm_q <= res_nx.right_duty;
				held_left_fwd_q  <= res_nx.left_dir;
				held_right_fwd_q <= res_nx.right_dir;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			word_s1 <= in_word_t'(s_axis_tdata);
		if (load_s2)
			res_s2 <= res_nx;
	end

endmodule

[hw/rtl/ddmc_checker.sv]
`timescale 1ns / 1ps

module ddmc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [ddmc_pkg::OutW-1:0] m_axis_tdata
);
	import ddmc_pkg::*;

	out_word_t w;
	assign w = out_word_t'(m_axis_tdata[OutFieldW-1:0]);

	// a forced stop always shows the stop command
	a_forced_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && w.forced_stop |->
			w.left_duty == '0 && w.right_duty == '0 && w.left_dir && w.right_dir)
		else $error("forced stop word carries a nonzero command");

	// avoidance only in autonomous mode and never together with a forced stop
	a_avoid_auto: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && w.avoidance_active |-> w.drive_mode && !w.forced_stop)
		else $error("avoidance flagged outside autonomous drive");

	// avoidance command is one of the three turn patterns
	a_avoid_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && w.avoidance_active |->
			(w.left_duty == AvoidFastPwm && w.right_duty == AvoidSlowPwm && w.left_dir) ||
			(w.left_duty == AvoidSlowPwm && w.right_duty == AvoidFastPwm && w.right_dir) ||
			(w.left_duty == ReversePwm && w.right_duty == ReversePwm && !w.left_dir))
		else $error("avoidance word is not a turn pattern");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

endmodule

bind differential_drive_mode_controller_core ddmc_checker u_ddmc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import ddmc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InW-1:0]      s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutW-1:0]     m_axis_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	differential_drive_mode_controller_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	localparam side_t StopSide    = '{pwm: 8'd0, fwd: 1'b1};
	localparam side_t ReverseSide = '{pwm: ReversePwm, fwd: 1'b0};
	localparam int    LongStall   = 300;

	// predictor copy of registers and state
	logic [31:0] safe_dist  = SafeDistanceRst;
	logic [23:0] arrive_tol = ArrivalTolRst;
	logic [7:0]  base_spd   = BaseSpeedRst;
	logic [7:0]  steer_lim  = SteerLimitRst;
	logic        mode_auto  = 1'b0;
	side_t       held_l     = '0;
	side_t       held_r     = '0;

	out_word_t motor_q[$];
	bit        failed = 1'b0;
	bit        tx_calm = 1'b0;
	bit        rx_calm = 1'b0;
	int        stall_asks = 0;
	int        stall_seen = 0;
	int        stall_left = 0;

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic side_t drive_side(input int speed);
		side_t s;
		int mag;
		mag = (speed < 0) ? -speed : speed;
		s.fwd = (speed >= 0);
		s.pwm = (mag > int'(PwmMax)) ? PwmMax : mag[7:0];
		return s;
	endfunction

	task automatic advance_drive(input in_word_t w);
		int fwd, turn, err, steer, lim;
		logic blk_l, blk_r;
		out_word_t cmd;
		cmd = '0;
		if (w.mode_button)
			mode_auto = !mode_auto;
		if (w.estop_req) begin
			held_l = StopSide;
			held_r = StopSide;
			cmd.forced_stop = 1'b1;
		end else if (w.mode_button) begin
			// command held
		end else if (!mode_auto) begin
			fwd = int'($signed(w.joy_y)) / 128;
			turn = int'($signed(w.joy_x)) / 128;
			held_l = drive_side(fwd - turn);
			held_r = drive_side(fwd + turn);
		end else if (!w.gps_fix) begin
			held_l = StopSide;
			held_r = StopSide;
			cmd.forced_stop = 1'b1;
		end else begin
			blk_l = w.front_left_range < safe_dist;
			blk_r = w.front_right_range < safe_dist;
			if (blk_l || blk_r) begin
				cmd.avoidance_active = 1'b1;
				if (blk_l && !blk_r) begin
					held_l = '{pwm: AvoidFastPwm, fwd: 1'b1};
					held_r = '{pwm: AvoidSlowPwm, fwd: 1'b1};
				end else if (blk_r && !blk_l) begin
					held_l = '{pwm: AvoidSlowPwm, fwd: 1'b1};
					held_r = '{pwm: AvoidFastPwm, fwd: 1'b1};
				end else begin
					held_l = ReverseSide;
					held_r = ReverseSide;
				end
			end else if (w.waypoint_distance_cm < arrive_tol) begin
				held_l.pwm = '0;
				held_r.pwm = '0;
			end else begin
				lim = int'(steer_lim);
				err = int'(w.waypoint_bearing);
				if (err > int'(BearingMax))
					err -= int'(BearingFull);
				if (err > int'(BearingHalf))
					err -= int'(BearingFull);
				steer = err / 8;
				if (steer > lim)
					steer = lim;
				if (steer < -lim)
					steer = -lim;
				held_l = drive_side(int'(base_spd) - steer);
				held_r = drive_side(int'(base_spd) + steer);
			end
		end
		cmd.left_duty = held_l.pwm;
		cmd.right_duty = held_r.pwm;
		cmd.left_dir = held_l.fwd;
		cmd.right_dir = held_r.fwd;
		cmd.drive_mode = mode_auto;
		motor_q.push_back(cmd);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	task automatic check_command(input logic [OutW-1:0] data);
		out_word_t got, want;
		got = data[OutFieldW-1:0];
		if (motor_q.size() == 0) begin
			$error("motor command with none expected: %h", data);
			failed = 1'b1;
		end else begin
			want = motor_q.pop_front();
			compare_field("left_duty", want.left_duty, got.left_duty);
			compare_field("right_duty", want.right_duty, got.right_duty);
			compare_field("left_dir", want.left_dir, got.left_dir);
			compare_field("right_dir", want.right_dir, got.right_dir);
			compare_field("drive_mode", want.drive_mode, got.drive_mode);
			compare_field("avoidance_active", want.avoidance_active,
				got.avoidance_active);
			compare_field("forced_stop", want.forced_stop, got.forced_stop);
		end
	endtask

	// receiver: checks each word, random stalls, long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_command(m_axis_tdata);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_asks != stall_seen) begin
				stall_seen <= stall_asks;
				stall_left <= LongStall;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= rx_calm || ($urandom_range(99) >= 24);
			end
		end
	end

	task automatic send_tick(input in_word_t w);
		if (!tx_calm) begin
			while ($urandom_range(99) < 24) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		advance_drive(w);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (motor_q.size() != 0);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CfgSafeDistance: safe_dist = val;
			CfgArrivalTol:   arrive_tol = val[23:0];
			CfgBaseSpeed:    base_spd = val[7:0];
			CfgSteerLimit:   steer_lim = val[7:0];
			default: ;
		endcase
	endtask

	// upper data bits are junk and must be dropped; last write hits no register
	task automatic set_regs(input logic [31:0] sd, input logic [23:0] tol,
			input logic [7:0] spd, input logic [7:0] lim);
		cfg_write(CfgSafeDistance, sd);
		cfg_write(CfgArrivalTol, {8'($urandom), tol});
		cfg_write(CfgBaseSpeed, {24'($urandom), spd});
		cfg_write(CfgSteerLimit, {24'($urandom), lim});
		cfg_write(8'($urandom_range(int'(CfgSteerLimit) + 1, 255)), $urandom);
		cfg_we <= 1'b0;
	endtask

	function automatic in_word_t make_tick(input int jx, input int jy, input bit btn,
			input logic [31:0] fl, input logic [31:0] fr, input bit es, input bit fix,
			input logic [23:0] wp_dist, input logic [12:0] brg);
		in_word_t w;
		w.joy_x = jx[15:0];
		w.joy_y = jy[15:0];
		w.mode_button = btn;
		w.front_left_range = fl;
		w.front_right_range = fr;
		w.estop_req = es;
		w.gps_fix = fix;
		w.waypoint_distance_cm = wp_dist;
		w.waypoint_bearing = brg;
		return w;
	endfunction

	function automatic logic [31:0] pick_range();
		case ($urandom_range(0, 7))
			0: return safe_dist - 1;
			1: return safe_dist;
			2: return safe_dist + $urandom_range(0, 50);
			3: return '1;
			4: return $urandom_range(0, 3000);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t rand_tick();
		in_word_t w;
		if ($urandom_range(99) < 70) begin
			w.joy_x = 16'($urandom);
			w.joy_y = 16'($urandom);
		end else begin
			w.joy_x = 16'($urandom_range(0, 511) - 256);
			w.joy_y = 16'($urandom_range(0, 511) - 256);
		end
		w.mode_button = ($urandom_range(99) < 12);
		w.front_left_range = pick_range();
		w.front_right_range = pick_range();
		w.estop_req = ($urandom_range(99) < 6);
		w.gps_fix = ($urandom_range(99) >= 8);
		case ($urandom_range(0, 9))
			6: w.waypoint_distance_cm = arrive_tol - 1;
			7: w.waypoint_distance_cm = arrive_tol;
			8: w.waypoint_distance_cm = '1;
			9: w.waypoint_distance_cm = 24'($urandom_range(0, 1000));
			default: w.waypoint_distance_cm = 24'($urandom);
		endcase
		if ($urandom_range(99) < 80)
			w.waypoint_bearing = 13'($urandom_range(0, int'(BearingMax)));
		else
			w.waypoint_bearing = 13'($urandom);
		return w;
	endfunction

	task automatic run_directed();
		// manual mix: zero, saturation both ways, truncation toward zero
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(0, 32767, 0, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(-32768, -32768, 0, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(32767, -32768, 0, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(-127, 127, 0, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(-128, -129, 0, 0, 0, 0, 1, 0, 0));
		// emergency in manual, then button into autonomous keeps the command
		send_tick(make_tick(5000, 9000, 0, 0, 0, 1, 1, 0, 0));
		send_tick(make_tick(12000, 3000, 1, 0, 0, 0, 1, 0, 0));
		// gps loss, obstacles
		send_tick(make_tick(0, 0, 0, 5000, 5000, 0, 0, 9000, 0));
		send_tick(make_tick(0, 0, 0, 999, 5000, 0, 1, 9000, 0));
		send_tick(make_tick(0, 0, 0, 5000, 999, 0, 1, 9000, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, 9000, 0));
		// arrival keeps the reverse direction bits
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 499, 0));
		// steering around the wrap points and the clamp
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 0));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 2880));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 2881));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 5759));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 5760));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 8191));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 40));
		send_tick(make_tick(0, 0, 0, 1000, 1000, 0, 1, 500, 5720));
		// emergency beats gps loss; emergency with button toggles and stops
		send_tick(make_tick(0, 0, 0, 0, 0, 1, 0, 0, 0));
		send_tick(make_tick(0, 0, 1, 0, 0, 1, 1, 0, 0));
		send_tick(make_tick(300, 300, 1, 0, 0, 0, 1, 0, 0));
		send_tick(make_tick(-1, -1, 0, '1, '1, 0, 1, '1, '1));
		send_tick(make_tick(0, 0, 1, 0, 0, 0, 1, 0, 0));
	endtask

	task automatic run_phase(input logic [31:0] sd, input logic [23:0] tol,
			input logic [7:0] spd, input logic [7:0] lim, input int count);
		drain();
		set_regs(sd, tol, spd, lim);
		repeat (count) send_tick(rand_tick());
	endtask

	task automatic run_settings();
		run_phase(32'd0, 24'd0, 8'd0, 8'd0, 260);
		run_phase('1, '1, 8'd255, 8'd255, 260);
		run_phase(32'd1000, 24'd500, 8'd255, 8'd255, 260);
		run_phase($urandom, 24'($urandom), 8'($urandom), 8'($urandom), 260);
		run_phase(32'd2000, 24'd100000, 8'd0, 8'd255, 260);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_phase(SafeDistanceRst, ArrivalTolRst, BaseSpeedRst, SteerLimitRst, 260);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic run_backpressure();
		tx_calm = 1'b1;
		stall_asks <= stall_asks + 1;
		repeat (80) send_tick(rand_tick());
		tx_calm = 1'b0;
	endtask

	task automatic run_pause_midstream();
		repeat (100) send_tick(rand_tick());
		drain();
		repeat (100) send_tick(rand_tick());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_settings();
		run_backpressure();
		run_pause_midstream();
		drain();
		repeat (8) @(posedge clk);
		if (failed || motor_q.size() != 0)
			$display("TB_ERROR");
		else
			$display("TB_OK");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ddmc_pkg.sv
hw/rtl/differential_drive_mode_controller_core.sv
hw/rtl/ddmc_checker.sv
tb/testbench.sv
